// File: hw/rtl/cdf_weighted_index_sampler_top_defines.svh
// Assertion macros shared by the checker of the weighted index sampler.
`ifndef CDF_WEIGHTED_INDEX_SAMPLER_TOP_DEFINES_SVH
`define CDF_WEIGHTED_INDEX_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDFWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDFWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cdfws_pkg.sv
// Shared constants and field layout of the weighted index sampler.
`default_nettype none

package cdfws_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 7;
    localparam int VALUE_W     = 32;

    // Slave tdata layout, lowest bit first
    localparam int IDX_LSB     = 0;
    localparam int VAL_LSB     = IDX_LSB + ADDR_W;
    localparam int RND_LSB     = VAL_LSB + VALUE_W;
    localparam int CNT_LSB     = RND_LSB + VALUE_W;
    localparam int S_FIELDS_W  = CNT_LSB + COUNT_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int M_TDATA_W   = ((ADDR_W + 7) / 8) * 8;

    // Word kinds carried on s_tuser
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/cdfws_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module cdfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/cdf_weighted_index_sampler_top.sv
// Inverse-CDF weighted index sampler: one cumulative table RAM and a scan sequencer.
//
// A load word (s_tuser = 0) writes one table entry in the cycle it is accepted and
// gives no result. A query word (s_tuser = 1) gives one result: s_tready stays low
// while it runs. A query with used_entries of 0 or 1 goes straight to the finish
// state as a miss. Otherwise the sequencer reads entry n-1 from the single-port
// table RAM (one read a cycle, registered read data), and a random value above it
// ends as a miss; else it scans entries 1..i one per cycle up to the first hit i.
// The result sits in an output register, so the next word is taken while a result
// waits on m_tready; a query only holds in its finish state if the previous result
// is still not taken.
`default_nettype none

module cdf_weighted_index_sampler_top
    import cdfws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // entry_index, entry_value, random_value, used_entries, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [0:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // chosen_index, zero pad
    output logic      [M_TDATA_W-1:0] m_tdata,
    // hit
    output logic      [0:0]           m_tuser
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BOUND  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

    logic [1:0]         state_reg, state_next;
    logic [VALUE_W-1:0] rnd_reg, rnd_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               res_hit_reg, res_hit_next;
    logic [ADDR_W-1:0]  res_idx_reg, res_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_hit_reg, m_hit_next;
    logic [ADDR_W-1:0]  m_idx_reg, m_idx_next;

    logic [ADDR_W-1:0]  in_idx;
    logic [VALUE_W-1:0] in_val;
    logic [VALUE_W-1:0] in_rnd;
    logic [COUNT_W-1:0] in_cnt;
    logic [COUNT_W-1:0] cnt_sat;
    logic [ADDR_W-1:0]  last_idx;
    logic               accept;
    logic               out_free;

    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_we;
    logic [VALUE_W-1:0] ram_rdata;

    assign in_idx   = s_tdata[IDX_LSB +: ADDR_W];
    assign in_val   = s_tdata[VAL_LSB +: VALUE_W];
    assign in_rnd   = s_tdata[RND_LSB +: VALUE_W];
    assign in_cnt   = s_tdata[CNT_LSB +: COUNT_W];
    assign cnt_sat  = (in_cnt > DEPTH_COUNT) ? DEPTH_COUNT : in_cnt;
    assign last_idx = ADDR_W'(cnt_sat - COUNT_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    cdfws_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (in_val),
        .rdata (ram_rdata)
    );

    // RAM address: load or bound read on accept, then entries 1, 2, ... during the scan
    always_comb
    begin
        ram_addr = cmp_idx_reg;
        ram_we   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tuser[0] == KIND_LOAD)
                begin
                    ram_addr = in_idx;
                    ram_we   = accept;
                end
                else
                begin
                    ram_addr = last_idx;
                end
            end
            ST_BOUND:  ram_addr = ADDR_W'(1);
            ST_SCAN:   ram_addr = cmp_idx_reg + ADDR_W'(1);
            ST_FINISH: ram_addr = cmp_idx_reg;
            default:   ram_addr = cmp_idx_reg;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        cmp_idx_next = cmp_idx_reg;
        res_hit_next = res_hit_reg;
        res_idx_next = res_idx_reg;
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_idx_next   = m_idx_reg;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser[0] == KIND_QUERY)
                begin
                    rnd_next     = in_rnd;
                    res_hit_next = 1'b0;
                    res_idx_next = '0;
                    if (cnt_sat <= COUNT_W'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND:
            begin
                // Entry n-1 bounds the scan: past it the query is a miss
                if (rnd_reg > ram_rdata)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmp_idx_next = ADDR_W'(1);
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Entry n-1 is known to qualify, so the scan stops by then
                if (rnd_reg <= ram_rdata)
                begin
                    res_hit_next = 1'b1;
                    res_idx_next = cmp_idx_reg;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + ADDR_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next;
        cmp_idx_reg <= cmp_idx_next;
        res_hit_reg <= res_hit_next;
        res_idx_reg <= res_idx_next;
        m_hit_reg   <= m_hit_next;
        m_idx_reg   <= m_idx_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = M_TDATA_W'(m_idx_reg);

endmodule

`default_nettype wire

// File: hw/rtl/cdfws_checker.sv
// Port-level checker for the weighted index sampler, bound to the top level.
`default_nettype none

`include "cdf_weighted_index_sampler_top_defines.svh"

module cdfws_checker
    import cdfws_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [0:0]           s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser
);

    logic load_acc;
    logic query_acc;
    logic m_hold;

    assign load_acc  = s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD);
    assign query_acc = s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY);
    assign m_hold    = m_tvalid && !m_tready;

    `CDFWS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_hold, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
    `CDFWS_ASSERT_NOW(a_miss_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero index")
    `CDFWS_ASSERT_NOW(a_hit_nonzero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[ADDR_W-1:0] != '0, "hit on index zero")
    `CDFWS_ASSERT_NEXT(a_load_silent, clk, rst_n, load_acc, !$rose(m_tvalid), "load word produced a result")
    `CDFWS_ASSERT_NEXT(a_query_busy, clk, rst_n, query_acc, !s_tready, "query accepted without a busy cycle")

endmodule

bind cdf_weighted_index_sampler_top cdfws_checker u_cdfws_checker (.*);

`default_nettype wire

// File: sim/tb_cdf_weighted_index_sampler_top.sv
// Self-checking testbench for the weighted index sampler: table loads, queries, stalls.
`default_nettype none

module tb_cdf_weighted_index_sampler_top;
    import cdfws_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_WORDS  = 1850;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TAIL_CYCLES   = 2 * TABLE_DEPTH + 16;
    localparam int PLAN_ROWS     = 23;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] chosen;
    } pick_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  idx;
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] rnd;
        logic [COUNT_W-1:0] cnt;
        logic               typed;
        logic               hit;
        logic [ADDR_W-1:0]  chosen;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    logic [VALUE_W-1:0]   weight_table [TABLE_DEPTH];
    pick_t                picks_due [$];
    plan_row_t            plan_rows [PLAN_ROWS];
    int                   failures     = 0;
    int                   words_sent   = 0;
    int                   picks_seen   = 0;
    int                   burst_left   = 0;
    int                   idle_cycles  = 0;

    cdf_weighted_index_sampler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Linear scan over the cumulative table: first entry not below the draw
    function automatic pick_t predict_pick(input logic [VALUE_W-1:0] r,
                                           input logic [COUNT_W-1:0] n);
        int    span;
        pick_t p;
        span = (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
        p = '0;
        if (span > 1 && r <= weight_table[span-1])
        begin
            for (int i = 1; i < span && !p.hit; i++)
            begin
                if (r <= weight_table[i])
                begin
                    p.hit    = 1'b1;
                    p.chosen = i[ADDR_W-1:0];
                end
            end
        end
        return p;
    endfunction

    task automatic rest(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic offer_word(input logic kind, input logic [ADDR_W-1:0] idx,
                              input logic [VALUE_W-1:0] val, input logic [VALUE_W-1:0] rnd,
                              input logic [COUNT_W-1:0] cnt, input logic typed,
                              input pick_t typed_pick);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[IDX_LSB +: ADDR_W]  = idx;
        w[VAL_LSB +: VALUE_W] = val;
        w[RND_LSB +: VALUE_W] = rnd;
        w[CNT_LSB +: COUNT_W] = cnt;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (kind == KIND_LOAD)
            weight_table[idx] = val;
        else
            picks_due.insert(picks_due.size(), typed ? typed_pick : predict_pick(rnd, cnt));
        // pace the sender in bursts; some bursts run back to back
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0)
                rest($urandom_range(1, 12));
        end
    endtask

    task automatic send_load(input logic [ADDR_W-1:0] idx, input logic [VALUE_W-1:0] val);
        offer_word(KIND_LOAD, idx, val, $urandom, COUNT_W'($urandom), 1'b0, '0);
    endtask

    task automatic send_query(input logic [VALUE_W-1:0] rnd, input logic [COUNT_W-1:0] cnt);
        offer_word(KIND_QUERY, ADDR_W'($urandom), $urandom, rnd, cnt, 1'b0, '0);
    endtask

    // Fill of entries 0..k-1, monotonic from entry 1, ties and a saturated top now and then
    task automatic fill_table(input int k);
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] cap;
        acc = ($urandom_range(0, 7) == 0) ? $urandom : '0;
        send_load('0, acc);
        acc = '0;
        cap = ($urandom_range(0, 2) == 0) ? 32'd16 : 32'hFFFF_FFFF / k;
        for (int i = 1; i < k; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                acc = acc + VALUE_W'($urandom % (cap + 33'd1));
            if (i == k - 1 && $urandom_range(0, 4) == 0)
                acc = '1;
            send_load(i[ADDR_W-1:0], acc);
        end
    endtask

    function automatic logic [COUNT_W-1:0] draw_count(input int fill_top);
        case ($urandom_range(0, 9))
            0:       return COUNT_W'($urandom_range(0, 1));
            1:       return COUNT_W'($urandom_range(TABLE_DEPTH + 1, 127));
            2:       return COUNT_W'(TABLE_DEPTH);
            3, 4:    return COUNT_W'($urandom_range(2, TABLE_DEPTH));
            default: return COUNT_W'($urandom_range(2, fill_top));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] draw_random(input logic [COUNT_W-1:0] n);
        int                 span;
        logic [VALUE_W-1:0] top;
        span = (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
        top  = weight_table[(span > 1) ? span - 1 : 1];
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return weight_table[$urandom_range(1, TABLE_DEPTH - 1)];
            2:       return weight_table[$urandom_range(1, TABLE_DEPTH - 1)] + 32'd1;
            3:       return top + 32'd1;
            default: return (top == '1) ? $urandom : VALUE_W'($urandom % (top + 33'd1));
        endcase
    endfunction

    // Receiver: changing stall patterns, with one long hold-off once 60 results are taken
    initial
    begin
        int  span;
        int  mode;
        int  tick;
        bit  held_off;
        held_off = 1'b0;
        tick     = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && picks_seen >= 60)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= (tick % 4) != 0;
                    default: m_tready <= $urandom_range(0, 4) == 0;
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            picks_seen++;
            if (picks_due.size() == 0)
            begin
                $error("result word with nothing expected: hit %0d chosen_index %0d",
                       m_tuser[0], m_tdata[ADDR_W-1:0]);
                failures++;
            end
            else
            begin
                want = picks_due.pop_front();
                if (m_tuser[0] !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, m_tuser[0]);
                    failures++;
                end
                if (m_tdata[ADDR_W-1:0] !== want.chosen)
                begin
                    $error("chosen_index: expected %0d, actual %0d",
                           want.chosen, m_tdata[ADDR_W-1:0]);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("FAIL cdf_weighted_index_sampler_top");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int          fill_top;
        int          reps;
        bit          drained_once;
        logic [6:0]  n;
        pick_t       typed_pick;
        drained_once = 1'b0;
        fill_top     = TABLE_DEPTH;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        plan_rows = '{
            // kind       idx    val             rnd             cnt     typed hit  chosen
            '{KIND_QUERY, 6'd0,  32'd0,          32'd0,          7'd0,   1'b1, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'hFFFF_FFFF,  7'd1,   1'b1, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd0,  32'd0,          32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd1,  32'd100,        32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd2,  32'd100,        32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd3,  32'd5000,       32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd4,  32'hFFFF_FFFE,  32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd0,          7'd2,   1'b1, 1'b1, 6'd1},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd100,        7'd5,   1'b1, 1'b1, 6'd1},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd101,        7'd5,   1'b1, 1'b1, 6'd3},
            '{KIND_QUERY, 6'd0,  32'd0,          32'hFFFF_FFFE,  7'd5,   1'b1, 1'b1, 6'd4},
            '{KIND_QUERY, 6'd0,  32'd0,          32'hFFFF_FFFF,  7'd5,   1'b1, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd101,        7'd3,   1'b1, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd12345,      7'd5,   1'b0, 1'b0, 6'd0},
            // entry 0 is never compared, whatever it holds
            '{KIND_LOAD,  6'd0,  32'hDEAD_BEEF,  32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd50,         7'd2,   1'b1, 1'b1, 6'd1},
            '{KIND_LOAD,  6'd63, 32'hFFFF_FFFF,  32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            // decreasing table: first entry at or above the draw still wins
            '{KIND_LOAD,  6'd1,  32'd6000,       32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_LOAD,  6'd2,  32'd10,         32'd0,          7'd0,   1'b0, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd4000,       7'd4,   1'b1, 1'b1, 6'd1},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd5500,       7'd4,   1'b1, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd20,         7'd3,   1'b1, 1'b0, 6'd0},
            '{KIND_QUERY, 6'd0,  32'd0,          32'd7,          7'd5,   1'b0, 1'b0, 6'd0}
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            typed_pick.hit    = plan_rows[i].hit;
            typed_pick.chosen = plan_rows[i].chosen;
            offer_word(plan_rows[i].kind, plan_rows[i].idx, plan_rows[i].val,
                       plan_rows[i].rnd, plan_rows[i].cnt, plan_rows[i].typed, typed_pick);
        end

        // every entry must hold a written value before random counts are drawn
        fill_table(TABLE_DEPTH);
        while (words_sent < PLAN_ROWS + RANDOM_WORDS)
        begin
            if (!drained_once && words_sent > PLAN_ROWS + RANDOM_WORDS / 2)
            begin
                drained_once = 1'b1;
                rest(1);
                while (picks_due.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    fill_top = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : $urandom_range(2, 12);
                    fill_table(fill_top);
                    reps = $urandom_range(1, 8);
                    repeat (reps)
                    begin
                        n = draw_count(fill_top);
                        send_query(draw_random(n), n);
                    end
                end
                3, 4, 5, 6, 7:
                begin
                    reps = $urandom_range(1, 10);
                    repeat (reps)
                    begin
                        n = draw_count(fill_top);
                        send_query(draw_random(n), n);
                    end
                end
                8:
                begin
                    // stray loads break the ordering of the table
                    reps = $urandom_range(1, 4);
                    repeat (reps)
                        send_load(ADDR_W'($urandom), $urandom);
                end
                default:
                    send_query($urandom, COUNT_W'($urandom));
            endcase
        end
        rest(0);

        while (picks_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS cdf_weighted_index_sampler_top");
        else
            $display("FAIL cdf_weighted_index_sampler_top");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/cdfws_pkg.sv
hw/rtl/cdfws_ram.sv
hw/rtl/cdf_weighted_index_sampler_top.sv
hw/rtl/cdfws_checker.sv
sim/tb_cdf_weighted_index_sampler_top.sv
